/* src/tcpwq_pkg.sv */
// Shared types and constants for the two-class priority wait queue.
// Used by tcpwq_ctrl, tcpwq_dp and two_class_priority_wait_queue.
`timescale 1ns / 1ps

package tcpwq_pkg;

  // Default queue depth
  localparam int DEPTH_DEF = 16;

  // Entry key: {class bit, request time, identifier}
  localparam int TIME_W = 16;
  localparam int IDENT_W = 16;
  localparam int KEY_W = 1 + TIME_W + IDENT_W;
  localparam int OCC_W = 5;
  localparam int STAT_W = 2;

  // Stream word widths (packed fields rounded up to whole bytes)
  localparam int IN_FIELDS_W = KEY_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + KEY_W + OCC_W + 1 + KEY_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes carried in in_tuser
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_IDX_M1 = 2'd0,
    RD_IDX = 2'd1,
    RD_ZERO = 2'd2
  } rd_sel_t;

  // Memory write address/data source
  typedef enum logic [1:0] {
    WR_SHIFT_UP = 2'd0, // mem[idx]   <= read word
    WR_KEY = 2'd1,      // mem[idx]   <= new key
    WR_SHIFT_DN = 2'd2  // mem[idx-1] <= read word
  } wr_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic idx_ld_cnt;
    logic idx_ld_one;
    logic idx_dec;
    logic idx_inc;
    logic rd_en;
    rd_sel_t rd_sel;
    logic wr_en;
    wr_sel_t wr_sel;
    logic cnt_inc;
    logic cnt_dec;
    logic last_ld;
    logic out_ld;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_remove;
    logic is_full;
    logic is_empty;
    logic idx_zero;
    logic idx_at_cnt;
    logic move_up;
    logic out_busy;
  } sts_t;

endpackage

/* src/tcpwq_ctrl.sv */
// Controller state machine for the two-class priority wait queue.
// Depends on tcpwq_pkg for the command and status structs.
`timescale 1ns / 1ps

module tcpwq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  tcpwq_pkg::sts_t sts,
  output tcpwq_pkg::cmd_t cmd
);
  import tcpwq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DISPATCH  = 9'b000000010,
    S_INS_TEST  = 9'b000000100,
    S_INS_CMP   = 9'b000001000,
    S_REM_FIRST = 9'b000010000,
    S_REM_TEST  = 9'b000100000,
    S_REM_MOVE  = 9'b001000000,
    S_HEAD_RD   = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_sel = RD_ZERO;
    cmd.wr_sel = WR_KEY;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_remove) begin
          if (sts.is_empty) begin
            state_nxt = S_HEAD_RD;
          end else begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_ZERO;
            cmd.idx_ld_one = 1'b1;
            state_nxt = S_REM_FIRST;
          end
        end else begin
          if (sts.is_full) begin
            state_nxt = S_HEAD_RD;
          end else begin
            cmd.idx_ld_cnt = 1'b1;
            state_nxt = S_INS_TEST;
          end
        end
      end
      // Walk down from the tail; an empty slot at idx is ready
      S_INS_TEST: begin
        if (sts.idx_zero) begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = WR_KEY;
          cmd.cnt_inc = 1'b1;
          state_nxt = S_HEAD_RD;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_nxt = S_INS_CMP;
        end
      end
      // Entries equal to or above the key move up one slot
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.move_up) begin
          cmd.wr_sel = WR_SHIFT_UP;
          cmd.idx_dec = 1'b1;
          state_nxt = S_INS_TEST;
        end else begin
          cmd.wr_sel = WR_KEY;
          cmd.cnt_inc = 1'b1;
          state_nxt = S_HEAD_RD;
        end
      end
      S_REM_FIRST: begin
        cmd.last_ld = 1'b1;
        state_nxt = S_REM_TEST;
      end
      // Close the gap left by the popped head
      S_REM_TEST: begin
        if (sts.idx_at_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt = S_HEAD_RD;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt = S_REM_MOVE;
        end
      end
      S_REM_MOVE: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = WR_SHIFT_DN;
        cmd.idx_inc = 1'b1;
        state_nxt = S_REM_TEST;
      end
      S_HEAD_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/tcpwq_dp.sv */
// Datapath for the two-class priority wait queue: entry memory, index,
// count, held copy and output register. Depends on tcpwq_pkg.
`timescale 1ns / 1ps

module tcpwq_dp #(
  parameter int QUEUE_DEPTH = tcpwq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcpwq_pkg::cmd_t                   cmd,
  output tcpwq_pkg::sts_t                   sts,
  input  logic [tcpwq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tcpwq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcpwq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [KEY_W-1:0] mem [QUEUE_DEPTH];
  logic [KEY_W-1:0] rdata_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] last_r, last_nxt;
  logic func_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CW-1:0] idx_r, idx_nxt, idx_m1;
  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [KEY_W-1:0] in_key, removed, head;
  logic cnt_full, cnt_empty;
  logic [OUT_FIELDS_W-1:0] fields;

  // Key order: class bit on top, then time, then identifier
  assign in_key = {in_tdata[0], in_tdata[TIME_W:1], in_tdata[KEY_W-1:TIME_W+1]};
  assign idx_m1 = idx_r - 1'b1;
  assign cnt_full = (count_r == CW'(QUEUE_DEPTH));
  assign cnt_empty = (count_r == '0);

  // Status to controller
  assign sts.is_remove = func_r;
  assign sts.is_full = cnt_full;
  assign sts.is_empty = cnt_empty;
  assign sts.idx_zero = (idx_r == '0);
  assign sts.idx_at_cnt = (idx_r == count_r);
  assign sts.move_up = (rdata_r >= key_r);
  assign sts.out_busy = out_valid_r && !out_tready;

  // Memory address and data selection
  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      RD_IDX:    rd_addr = idx_r[AW-1:0];
      RD_ZERO:   rd_addr = '0;
      default:   rd_addr = '0;
    endcase
    unique case (cmd.wr_sel)
      WR_SHIFT_UP: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = rdata_r;
      end
      WR_KEY: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = key_r;
      end
      WR_SHIFT_DN: begin
        wr_addr = idx_m1[AW-1:0];
        wr_data = rdata_r;
      end
      default: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = key_r;
      end
    endcase
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Index, count, held copy and status next values
  always_comb begin
    priority if (cmd.idx_ld_cnt) begin
      idx_nxt = count_r;
    end else if (cmd.idx_ld_one) begin
      idx_nxt = CW'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end else begin
      idx_nxt = idx_r;
    end

    priority if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end

    last_nxt = cmd.last_ld ? rdata_r : last_r;

    if (in_tuser == FUNC_REMOVE) begin
      status_nxt = cnt_empty ? STAT_EMPTY : STAT_OK;
    end else begin
      status_nxt = cnt_full ? STAT_FULL : STAT_OK;
    end
  end

  // Result word assembly
  assign removed = (func_r == FUNC_REMOVE) ? last_r : '0;
  assign head = cnt_empty ? '0 : rdata_r;
  assign fields = {head[IDENT_W-1:0], head[KEY_W-2:IDENT_W], head[KEY_W-1],
                   !cnt_empty, OCC_W'(count_r),
                   removed[IDENT_W-1:0], removed[KEY_W-2:IDENT_W], removed[KEY_W-1],
                   status_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      last_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      key_r <= in_key;
      func_r <= in_tuser;
      status_r <= status_nxt;
    end
    if (cmd.out_ld) begin
      out_data_r <= OUT_TDATA_W'(fields);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

/* src/two_class_priority_wait_queue.sv */
// Accept to result: insert walks down from the tail, reading and then writing each entry
// it moves; remove reads the head and shifts every later entry down; a dropped insert or
// empty remove goes straight to the head read. One word in flight: the next word is taken
// in the cycle after the result loads, and each entry moved takes a read and then a write.
// A result not yet taken holds the block. Reset (rst_n, synchronous, active low) empties
// the queue and clears the held copy; entry memory contents are not cleared.
`timescale 1ns / 1ps

module two_class_priority_wait_queue #(
  parameter int QUEUE_DEPTH = tcpwq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] is_takeoff, [16:1] request_time, [32:17] ident, [39:33] zero
  input  logic [tcpwq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] func (0 insert, 1 remove)
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [2] removed_takeoff, [18:3] removed_time, [34:19] removed_ident,
  // [39:35] occupancy, [40] head_valid, [41] head_takeoff, [57:42] head_time,
  // [73:58] head_ident, [79:74] zero
  output logic [tcpwq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcpwq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcpwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcpwq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A dropped insert only happens with the queue at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == STAT_FULL) |-> out_tdata[39:35] == OCC_W'(QUEUE_DEPTH))
    else $error("full status with wrong occupancy");

  // Remove on empty leaves an empty queue with no head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == STAT_EMPTY) |-> (out_tdata[39:35] == '0 && !out_tdata[40]))
    else $error("empty status with nonempty queue");

  // One word in flight: no accept right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while busy");

  // Count never goes past the depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.is_full)
    else $error("count increment at full");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for two_class_priority_wait_queue: an internal sorted-queue
// predictor scores every result word. Depends on tcpwq_pkg and the queue top level.
`timescale 1ns / 1ps

module tb_top;
  import tcpwq_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_OFF_AT = 200;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RAND_BURSTS = 15;
  localparam int BURST_LEN = 30;

  // One result word, split into its fields
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               rem_takeoff;
    logic [TIME_W-1:0]  rem_time;
    logic [IDENT_W-1:0] rem_ident;
    logic [OCC_W-1:0]   occupancy;
    logic               head_valid;
    logic               head_takeoff;
    logic [TIME_W-1:0]  head_time;
    logic [IDENT_W-1:0] head_ident;
  } queue_result_t;

  // Sorted wait queue model plus the list of result words still owed by the block
  class queue_scoreboard;
    logic [KEY_W-1:0] waiting[$];
    logic [KEY_W-1:0] held_copy;
    queue_result_t    owed_results[$];
    int               errors;

    function new();
      held_copy = '0;
      errors = 0;
    endfunction

    // Apply one accepted request word and queue the result it must produce
    function void note_request(logic func, logic [KEY_W-1:0] key);
      queue_result_t r;
      int pos;
      r = '0;
      r.status = STAT_OK;
      if (func == FUNC_INSERT) begin
        if (waiting.size() >= DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          // new key goes ahead of every equal or larger key
          pos = 0;
          while (pos < waiting.size() && waiting[pos] < key) pos++;
          waiting.insert(pos, key);
        end
      end else begin
        if (waiting.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          held_copy = waiting.pop_front();
        end
        {r.rem_takeoff, r.rem_time, r.rem_ident} = held_copy;
      end
      r.occupancy = OCC_W'(waiting.size());
      if (waiting.size() > 0) begin
        r.head_valid = 1'b1;
        {r.head_takeoff, r.head_time, r.head_ident} = waiting[0];
      end
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Score one accepted result word against the oldest owed result
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      queue_result_t e;
      if (owed_results.size() == 0) begin
        $error("result word %h arrived with nothing owed", word);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      compare_field("status", 16'(e.status), 16'(word[1:0]));
      compare_field("removed_takeoff", 16'(e.rem_takeoff), 16'(word[2]));
      compare_field("removed_time", e.rem_time, word[18:3]);
      compare_field("removed_ident", e.rem_ident, word[34:19]);
      compare_field("occupancy", 16'(e.occupancy), 16'(word[39:35]));
      compare_field("head_valid", 16'(e.head_valid), 16'(word[40]));
      compare_field("head_takeoff", 16'(e.head_takeoff), 16'(word[41]));
      compare_field("head_time", e.head_time, word[57:42]);
      compare_field("head_ident", e.head_ident, word[73:58]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = FUNC_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  queue_scoreboard sb;
  int sent_count = 0;
  int result_count = 0;
  int idle_cycles = 0;

  two_class_priority_wait_queue #(.QUEUE_DEPTH(DEPTH_DEF)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offer one request word; every fourth stretch of 40 words goes without gaps
  task automatic send_req(logic func, logic cls, logic [TIME_W-1:0] t,
                          logic [IDENT_W-1:0] id);
    int gap;
    gap = ((sent_count / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {{(IN_TDATA_W - KEY_W){1'b0}}, id, t, cls};
    do @(posedge clk); while (!in_tready);
    sb.note_request(func, {cls, t, id});
    sent_count++;
  endtask

  // Narrow values make equal times and identifiers common; wide ones toggle every bit
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus: directed corners, then bursts with shifting insert/remove mix
  initial begin
    int burst;
    int k;
    int p_insert;
    logic f;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // remove on empty right after reset shows a zero held copy
    send_req(FUNC_REMOVE, 1'b1, 16'hFFFF, 16'hFFFF);
    send_req(FUNC_INSERT, 1'b1, 16'hFFFF, 16'hFFFF);
    send_req(FUNC_INSERT, 1'b0, 16'h0000, 16'h0000);
    // exact duplicate goes ahead of the existing entry
    send_req(FUNC_INSERT, 1'b0, 16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 1'b1, 16'hFFFF, 16'hFFFE);
    send_req(FUNC_INSERT, 1'b0, 16'h1234, 16'h0005);
    send_req(FUNC_INSERT, 1'b0, 16'h1234, 16'h0004);
    send_req(FUNC_INSERT, 1'b1, 16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 1'b0, 16'hFFFF, 16'hFFFF);
    for (k = 0; k < 8; k++) begin
      send_req(FUNC_INSERT, 1'($urandom_range(0, 1)), pick_field(), pick_field());
    end
    // full queue drops even the smallest key
    send_req(FUNC_INSERT, 1'b0, 16'h0000, 16'h0000);
    for (k = 0; k < 4; k++) begin
      send_req(FUNC_REMOVE, 1'($urandom_range(0, 1)), pick_field(), pick_field());
    end

    for (burst = 0; burst < RAND_BURSTS; burst++) begin
      case (burst % 5)
        0: p_insert = 85;
        1: p_insert = 50;
        2: p_insert = 12;
        3: p_insert = 65;
        default: p_insert = 35;
      endcase
      for (k = 0; k < BURST_LEN; k++) begin
        f = ($urandom_range(0, 99) < p_insert) ? FUNC_INSERT : FUNC_REMOVE;
        send_req(f, 1'($urandom_range(0, 1)), pick_field(), pick_field());
      end
    end
    in_tvalid <= 1'b0;

    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off so the block backs up its input
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (result_count == HOLD_OFF_AT) begin
        gap = HOLD_OFF_CYCLES;
      end else if ((result_count / 35) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      result_count++;
    end
  end

  // Watchdog: too long without a word moving on either side ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
